// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the split timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/fgst_pkg.sv =====
// Shared types and constants of the four-gate split timer.
`timescale 1ns / 1ps
package fgst_pkg;

   localparam int unsigned TIME_BITS_DEF = 24;
   localparam int unsigned SPLIT_BITS    = 24;
   localparam int unsigned LOCKOUT_BITS  = 16;
   localparam int unsigned CMD_BITS      = 3;
   localparam int unsigned KIND_BITS     = 2;
   localparam int unsigned PHASE_BITS    = 3;
   localparam int unsigned GATES         = 4;

   localparam logic [LOCKOUT_BITS-1:0] LOCKOUT_RESET = 16'd1000;
   localparam logic [SPLIT_BITS-1:0]   SPLIT_MAX     = {SPLIT_BITS{1'b1}};

   // Request command codes.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK    = 3'd0,
      CMD_START   = 3'd1,
      CMD_RESET   = 3'd2,
      CMD_SAVE    = 3'd3,
      CMD_DISCARD = 3'd4
   } cmd_type;

   // Result kinds.
   typedef enum logic [KIND_BITS-1:0] {
      KIND_STATUS = 2'd0,
      KIND_PROMPT = 2'd1,
      KIND_RECORD = 2'd2
   } kind_type;

   // Run phases.
   typedef enum logic [PHASE_BITS-1:0] {
      PH_START          = 3'd0,
      PH_GATE_FIRST     = 3'd1,
      PH_GATE_CORNER_IN = 3'd2,
      PH_GATE_CORNER_OUT= 3'd3,
      PH_GATE_LAST      = 3'd4,
      PH_ENDED          = 3'd5,
      PH_DECIDE         = 3'd6,
      PH_DONE           = 3'd7
   } phase_type;

   // One request as held in the input register.
   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic                start_clear;
      logic [GATES-1:0]    levels;
      logic                link_up;
   } item_type;

   // Input register contents handed to the core.
   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

endpackage

// ===== hdl/fgst_ifs.sv =====
// Channel interfaces of the split timer: request, result and lockout write.
`timescale 1ns / 1ps
interface fgst_req_if;
   import fgst_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_BITS-1:0] cmd;
   logic                start_clear;
   logic                gate_first;
   logic                gate_corner_in;
   logic                gate_corner_out;
   logic                gate_last;
   logic                link_up;

   modport source (output valid, cmd, start_clear, gate_first, gate_corner_in,
                   gate_corner_out, gate_last, link_up, input ready);
   modport sink   (input valid, cmd, start_clear, gate_first, gate_corner_in,
                   gate_corner_out, gate_last, link_up, output ready);
endinterface

interface fgst_rsp_if;
   import fgst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  kind;
   logic [PHASE_BITS-1:0] phase;
   logic [SPLIT_BITS-1:0] split_first;
   logic [SPLIT_BITS-1:0] split_corner_in;
   logic [SPLIT_BITS-1:0] split_corner_out;
   logic [SPLIT_BITS-1:0] split_last;

   modport source (output valid, kind, phase, split_first, split_corner_in,
                   split_corner_out, split_last, input ready);
   modport sink   (input valid, kind, phase, split_first, split_corner_in,
                   split_corner_out, split_last, output ready);
endinterface

interface fgst_csr_if;
   import fgst_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [LOCKOUT_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/fgst_in_reg.sv =====
// Input register of the split timer: captures one request per cycle while the core keeps taking them.
`timescale 1ns / 1ps
module fgst_in_reg (
   input  logic               clock,
   input  logic               reset,
   fgst_req_if.sink           req_if,
   input  logic               advance,
   output fgst_pkg::stage_type stage
);
   import fgst_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // The register frees up whenever the core takes its contents.
   assign req_if.ready = !valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   // Next register contents.
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.cmd        = req_if.cmd;
         item_in.start_clear= req_if.start_clear;
         item_in.levels     = {req_if.gate_last, req_if.gate_corner_out,
                               req_if.gate_corner_in, req_if.gate_first};
         item_in.link_up    = req_if.link_up;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // Valid flag is reset; the payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ===== hdl/fgst_core.sv =====
// Run state, split capture and result register of the split timer.
`timescale 1ns / 1ps
module fgst_core #(
   parameter int unsigned TIME_BITS = fgst_pkg::TIME_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  fgst_pkg::stage_type stage,
   output logic                advance,
   fgst_rsp_if.source          rsp_if,
   fgst_csr_if.sink            csr_if
);
   import fgst_pkg::*;

   localparam int unsigned WIDE_BITS = (TIME_BITS > SPLIT_BITS) ? TIME_BITS : SPLIT_BITS;

   // Run state.
   phase_type              phase_ff, phase_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]   splits_ff [GATES];
   logic [TIME_BITS-1:0]   splits_in [GATES];
   logic [GATES-1:0]       prev_ff, prev_in;
   logic                   prompted_ff, prompted_in;
   logic [LOCKOUT_BITS-1:0] lockout_ff, lockout_in;

   // Result register.
   logic                   out_valid_ff, out_valid_in;
   logic [KIND_BITS-1:0]   out_kind_ff, out_kind_in;
   logic [PHASE_BITS-1:0]  out_phase_ff, out_phase_in;
   logic [SPLIT_BITS-1:0]  out_split_ff [GATES];
   logic [SPLIT_BITS-1:0]  out_split_in [GATES];

   logic                   take;
   logic                   emit;
   kind_type               kind_sel;
   logic [GATES-1:0]       rising;
   logic [1:0]             gate_idx;
   logic [1:0]             prev_idx;
   logic [TIME_BITS-1:0]   elapsed_step;
   logic [TIME_BITS-1:0]   since_split;
   logic                   armed;
   logic [WIDE_BITS-1:0]   wide_split [GATES];

   // The lockout register is always writable.
   assign csr_if.ready = 1'b1;
   assign lockout_in   = csr_if.valid ? csr_if.data : lockout_ff;

   // The core consumes a request when the result register is free or draining.
   assign advance = !out_valid_ff || rsp_if.ready;
   assign take    = stage.valid && advance;

   // Gate bookkeeping for phases that await a gate.
   assign rising       = stage.item.levels & ~prev_ff;
   assign gate_idx     = 2'(3'(phase_ff) - 3'd1);
   assign prev_idx     = gate_idx - 2'd1;
   assign elapsed_step = (elapsed_ff == {TIME_BITS{1'b1}}) ? elapsed_ff
                                                            : elapsed_ff + TIME_BITS'(1);
   assign since_split  = elapsed_step - splits_ff[prev_idx];
   assign armed        = (gate_idx == 2'd0) || (since_split > TIME_BITS'(lockout_ff));

   // Next run state for the request being consumed.
   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      splits_in   = splits_ff;
      prev_in     = prev_ff;
      prompted_in = prompted_ff;
      emit        = 1'b0;
      kind_sel    = KIND_STATUS;
      if (take) begin
         case (cmd_type'(stage.item.cmd))
            CMD_START, CMD_RESET: begin
               phase_in = PH_START;
            end
            CMD_SAVE: begin
               if (phase_ff == PH_DECIDE) begin
                  phase_in = PH_DONE;
                  emit     = 1'b1;
                  kind_sel = KIND_RECORD;
               end
            end
            CMD_DISCARD: begin
               if (phase_ff == PH_DECIDE) begin
                  phase_in = PH_DONE;
               end
            end
            CMD_TICK: begin
               prev_in = stage.item.levels;
               unique case (phase_ff)
                  PH_START: begin
                     for (int i = 0; i < GATES; i++) begin
                        splits_in[i] = '0;
                     end
                     prompted_in = 1'b0;
                     if (stage.item.start_clear) begin
                        elapsed_in = '0;
                        phase_in   = PH_GATE_FIRST;
                     end
                     emit = stage.item.link_up;
                  end
                  PH_GATE_FIRST, PH_GATE_CORNER_IN, PH_GATE_CORNER_OUT, PH_GATE_LAST: begin
                     elapsed_in = elapsed_step;
                     // Pending splits follow the elapsed count.
                     for (int i = 0; i < GATES; i++) begin
                        if (2'(i) >= gate_idx) begin
                           splits_in[i] = elapsed_step;
                        end
                     end
                     if (armed && rising[gate_idx]) begin
                        phase_in = phase_type'(3'(phase_ff) + 3'd1);
                     end
                     emit = stage.item.link_up;
                  end
                  PH_ENDED: begin
                     phase_in = PH_DECIDE;
                     emit     = stage.item.link_up;
                  end
                  PH_DECIDE: begin
                     if (stage.item.link_up && !prompted_ff) begin
                        prompted_in = 1'b1;
                        emit        = 1'b1;
                        kind_sel    = KIND_PROMPT;
                     end
                  end
                  PH_DONE: begin
                     emit = 1'b0;
                  end
               endcase
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // Result fields, with splits saturated to the output width.
   always_comb begin
      out_kind_in  = kind_sel;
      out_phase_in = phase_in;
      for (int i = 0; i < GATES; i++) begin
         wide_split[i] = WIDE_BITS'(splits_in[i]);
         if (wide_split[i] > WIDE_BITS'(SPLIT_MAX)) begin
            out_split_in[i] = SPLIT_MAX;
         end else begin
            out_split_in[i] = wide_split[i][SPLIT_BITS-1:0];
         end
      end
      if (take) begin
         out_valid_in = emit;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         elapsed_ff   <= '0;
         for (int i = 0; i < GATES; i++) begin
            splits_ff[i] <= '0;
         end
         prev_ff      <= '0;
         prompted_ff  <= 1'b0;
         lockout_ff   <= LOCKOUT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         splits_ff    <= splits_in;
         prev_ff      <= prev_in;
         prompted_ff  <= prompted_in;
         lockout_ff   <= lockout_in;
         out_valid_ff <= out_valid_in;
      end
      if (take && emit) begin
         out_kind_ff  <= out_kind_in;
         out_phase_ff <= out_phase_in;
         out_split_ff <= out_split_in;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.kind             = out_kind_ff;
   assign rsp_if.phase            = out_phase_ff;
   assign rsp_if.split_first      = out_split_ff[0];
   assign rsp_if.split_corner_in  = out_split_ff[1];
   assign rsp_if.split_corner_out = out_split_ff[2];
   assign rsp_if.split_last       = out_split_ff[3];

endmodule

// ===== hdl/four_gate_split_timer.sv =====
// Top level of the four-gate split timer.
// A result, where a request yields one, passes the input register and then the result register.
// Throughput: one request per cycle while results are taken, set by the input register and
// the state update feeding the result register.
// Reset is synchronous and active high: phase start, splits and elapsed zero,
// lockout 1000 ticks, no result pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module four_gate_split_timer #(
   parameter int unsigned TIME_BITS = fgst_pkg::TIME_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   fgst_req_if.sink     req_if,
   fgst_rsp_if.source   rsp_if,
   fgst_csr_if.sink     csr_if
);
   import fgst_pkg::*;

   stage_type stage;
   logic      advance;

   // Request capture.
   fgst_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .stage   (stage)
   );

   // Run state and result generation.
   fgst_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .rsp_if  (rsp_if),
      .csr_if  (csr_if)
   );

   // A record is sent only on the way into the done phase.
   `ASSERT_SAME(a_record_done, clock, reset, rsp_if.valid && rsp_if.kind == KIND_RECORD, rsp_if.phase == PH_DONE, "record result outside done phase")
   // A prompt is sent only while awaiting a decision.
   `ASSERT_SAME(a_prompt_decide, clock, reset, rsp_if.valid && rsp_if.kind == KIND_PROMPT, rsp_if.phase == PH_DECIDE, "prompt result outside decision phase")
   // A full input register behind a stalled result blocks new requests.
   `ASSERT_SAME(a_stall_blocks, clock, reset, stage.valid && rsp_if.valid && !rsp_if.ready, !req_if.ready, "request taken while both stages are stalled")
   // Reset leaves no result pending.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_if.valid, "result valid right after reset")

endmodule

// ===== tb/four_gate_split_timer_test.sv =====
// Self-checking testbench of the four-gate split timer with its own timing model.
`timescale 1ns / 1ps
module four_gate_split_timer_test;
   import fgst_pkg::*;

   localparam int unsigned TIME_BITS = TIME_BITS_DEF;
   localparam logic [31:0] ELAPSED_MAX = 32'((64'd1 << TIME_BITS) - 1);
   localparam int unsigned RUN_LIMIT = 300000;
   localparam int unsigned SETTLE_CYCLES = 6;

   // One result as the block reports it.
   typedef struct packed {
      kind_type              kind;
      phase_type             phase;
      logic [SPLIT_BITS-1:0] split_first;
      logic [SPLIT_BITS-1:0] split_corner_in;
      logic [SPLIT_BITS-1:0] split_corner_out;
      logic [SPLIT_BITS-1:0] split_last;
   } split_report_type;

   logic clock;
   logic reset;

   fgst_req_if req_bus ();
   fgst_rsp_if rsp_bus ();
   fgst_csr_if csr_bus ();

   four_gate_split_timer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Timing model state, starting from the reset values.
   logic [LOCKOUT_BITS-1:0] lockout_ticks = LOCKOUT_RESET;
   phase_type               run_phase = PH_START;
   logic [31:0]             elapsed = '0;
   logic [31:0]             split_time [GATES] = '{default: '0};
   logic [GATES-1:0]        last_levels = '0;
   bit                      prompt_sent = 1'b0;

   item_type         pending_items [$];
   split_report_type expected_reports [$];

   int unsigned send_idle = 18;
   int unsigned recv_idle = 49;
   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;
   int unsigned record_count = 0;
   int unsigned prompt_count = 0;
   int unsigned lockout_writes = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          req_taken = 1'b0;

   // Clock and cycle count.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Saturate a split to the width of the result field.
   function automatic logic [SPLIT_BITS-1:0] clip_split(input logic [31:0] value);
      return (value > 32'(SPLIT_MAX)) ? SPLIT_MAX : value[SPLIT_BITS-1:0];
   endfunction

   // Advance the timing model by one request; returns 1 when a result is due.
   function automatic bit advance_timer(input item_type it, output split_report_type rpt);
      logic [GATES-1:0] rising;
      int unsigned      g;
      bit               armed;
      bit               fires;
      kind_type         kind;
      fires = 1'b0;
      kind = KIND_STATUS;
      case (it.cmd)
         CMD_START, CMD_RESET: begin
            run_phase = PH_START;
         end
         CMD_SAVE: begin
            if (run_phase == PH_DECIDE) begin
               run_phase = PH_DONE;
               kind = KIND_RECORD;
               fires = 1'b1;
            end
         end
         CMD_DISCARD: begin
            if (run_phase == PH_DECIDE) run_phase = PH_DONE;
         end
         CMD_TICK: begin
            rising = it.levels & ~last_levels;
            last_levels = it.levels;
            case (run_phase)
               PH_START: begin
                  for (int i = 0; i < GATES; i++) split_time[i] = '0;
                  prompt_sent = 1'b0;
                  if (it.start_clear) begin
                     elapsed = '0;
                     run_phase = PH_GATE_FIRST;
                  end
                  fires = it.link_up;
               end
               PH_GATE_FIRST, PH_GATE_CORNER_IN, PH_GATE_CORNER_OUT, PH_GATE_LAST: begin
                  g = run_phase - 1;
                  if (elapsed < ELAPSED_MAX) elapsed = elapsed + 1;
                  for (int i = g; i < GATES; i++) split_time[i] = elapsed;
                  // Later gates wait out the lockout since the previous split.
                  armed = (g == 0) ? 1'b1 : ((elapsed - split_time[g-1]) > lockout_ticks);
                  if (armed && rising[g]) run_phase = phase_type'(run_phase + 1);
                  fires = it.link_up;
               end
               PH_ENDED: begin
                  run_phase = PH_DECIDE;
                  fires = it.link_up;
               end
               PH_DECIDE: begin
                  if (it.link_up && !prompt_sent) begin
                     prompt_sent = 1'b1;
                     kind = KIND_PROMPT;
                     fires = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      rpt.kind = kind;
      rpt.phase = run_phase;
      rpt.split_first = clip_split(split_time[0]);
      rpt.split_corner_in = clip_split(split_time[1]);
      rpt.split_corner_out = clip_split(split_time[2]);
      rpt.split_last = clip_split(split_time[3]);
      return fires;
   endfunction

   task automatic check_field(input string name, input logic [SPLIT_BITS-1:0] want,
                              input logic [SPLIT_BITS-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Monitor: checks results, tracks lockout writes and predicts each request.
   always @(posedge clock) begin
      split_report_type want;
      split_report_type got;
      item_type         it;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind = kind_type'(rsp_bus.kind);
            got.phase = phase_type'(rsp_bus.phase);
            got.split_first = rsp_bus.split_first;
            got.split_corner_in = rsp_bus.split_corner_in;
            got.split_corner_out = rsp_bus.split_corner_out;
            got.split_last = rsp_bus.split_last;
            if (expected_reports.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected, actual kind %0d phase %0d",
                        $time, got.kind, got.phase);
            end else begin
               want = expected_reports.pop_front();
               checked_count++;
               if (want.kind == KIND_RECORD) record_count++;
               if (want.kind == KIND_PROMPT) prompt_count++;
               check_field("kind", want.kind, got.kind);
               check_field("phase", want.phase, got.phase);
               check_field("split_first", want.split_first, got.split_first);
               check_field("split_corner_in", want.split_corner_in, got.split_corner_in);
               check_field("split_corner_out", want.split_corner_out, got.split_corner_out);
               check_field("split_last", want.split_last, got.split_last);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            lockout_ticks = csr_bus.data;
            lockout_writes++;
         end
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            accepted_count++;
            it.cmd = req_bus.cmd;
            it.start_clear = req_bus.start_clear;
            it.levels = {req_bus.gate_last, req_bus.gate_corner_out,
                         req_bus.gate_corner_in, req_bus.gate_first};
            it.link_up = req_bus.link_up;
            if (advance_timer(it, want)) expected_reports.push_back(want);
         end
      end
   end

   // Request driver: holds a request until taken, with random gaps.
   always @(negedge clock) begin
      item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            it = pending_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.cmd <= it.cmd;
            req_bus.start_clear <= it.start_clear;
            req_bus.gate_first <= it.levels[0];
            req_bus.gate_corner_in <= it.levels[1];
            req_bus.gate_corner_out <= it.levels[2];
            req_bus.gate_last <= it.levels[3];
            req_bus.link_up <= it.link_up;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver stalls at random.
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic queue_item(input logic [CMD_BITS-1:0] cmd, input logic clear,
                             input logic [GATES-1:0] levels, input logic link);
      item_type it;
      it.cmd = cmd;
      it.start_clear = clear;
      it.levels = levels;
      it.link_up = link;
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic queue_tick(input logic clear, input logic [GATES-1:0] levels);
      queue_item(CMD_TICK, clear, levels, $urandom_range(0, 4) != 0);
   endtask

   // Stray edges on gates other than the awaited one.
   function automatic logic [GATES-1:0] stray_levels(input int unsigned g);
      logic [GATES-1:0] lv;
      lv = GATES'($urandom & $urandom & $urandom);
      lv[g] = 1'b0;
      return lv;
   endfunction

   task automatic queue_noise(input int unsigned count);
      repeat (count) begin
         queue_item(CMD_BITS'($urandom_range(0, 7)), 1'($urandom), GATES'($urandom),
                    1'($urandom));
      end
   endtask

   // One run from the start line past the four gates to a decision.
   task automatic queue_run(input int unsigned lock);
      int unsigned tries;
      int unsigned gap;
      int unsigned hold;
      if ($urandom_range(0, 9) < 7) begin
         queue_item($urandom_range(0, 1) ? CMD_START : CMD_RESET, 1'($urandom),
                    GATES'($urandom), 1'($urandom));
      end
      repeat ($urandom_range(0, 3)) queue_tick(1'b0, GATES'($urandom));
      queue_tick(1'b1, 4'b0000);
      for (int unsigned g = 0; g < GATES; g++) begin
         tries = ($urandom_range(0, 3) == 0) ? 2 : 1;
         for (int unsigned t = 0; t < tries; t++) begin
            // An early attempt may fall inside the lockout and be ignored.
            if (lock > 40) gap = $urandom_range(1, 30);
            else if (t + 1 < tries) gap = $urandom_range(0, lock);
            else gap = lock + $urandom_range(0, 4);
            repeat (gap) queue_tick(1'($urandom), stray_levels(g));
            hold = $urandom_range(1, 3);
            repeat (hold) queue_tick(1'($urandom), stray_levels(g) | GATES'(1 << g));
         end
         if ($urandom_range(0, 40) == 0) begin
            queue_item(CMD_RESET, 1'b0, 4'b0000, 1'b1);
         end
      end
      repeat ($urandom_range(1, 4)) queue_tick(1'($urandom), GATES'($urandom));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: queue_item(CMD_SAVE, 1'($urandom), GATES'($urandom), 1'($urandom));
         5, 6, 7, 8: queue_item(CMD_DISCARD, 1'($urandom), GATES'($urandom), 1'($urandom));
         default: queue_item(CMD_START, 1'b0, 4'b0000, 1'b0);
      endcase
      repeat ($urandom_range(0, 2)) queue_tick(1'($urandom), GATES'($urandom));
   endtask

   // Wait until every request is taken and every result has come back.
   task automatic drain();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_lockout(input logic [LOCKOUT_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock);
      while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // One phase of random runs under one lockout and one idling pattern.
   task automatic run_phase_mix(input logic [LOCKOUT_BITS-1:0] lock,
                                input int unsigned s_idle, input int unsigned r_idle,
                                input int unsigned count);
      int unsigned stop_at;
      write_lockout(lock);
      send_idle = s_idle;
      recv_idle = r_idle;
      stop_at = queued_count + count;
      while (queued_count < stop_at) begin
         if ($urandom_range(0, 9) == 0) queue_noise($urandom_range(1, 6));
         else queue_run(lock);
      end
      drain();
   endtask

   // Timeout guard.
   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("four_gate_split_timer_test: done, errors");
      $finish;
   end

   // Reset, directed requests, then random phases.
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_TICK;
      req_bus.start_clear = 1'b0;
      req_bus.gate_first = 1'b0;
      req_bus.gate_corner_in = 1'b0;
      req_bus.gate_corner_out = 1'b0;
      req_bus.gate_last = 1'b0;
      req_bus.link_up = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: unknown codes, ignored commands, a full run and aborts.
      write_lockout('0);
      queue_item(CMD_TICK, 1'b0, 4'b1111, 1'b1);
      queue_item(CMD_BITS'(5), 1'b1, 4'b1111, 1'b1);
      queue_item(CMD_BITS'(6), 1'b1, 4'b1111, 1'b1);
      queue_item(CMD_BITS'(7), 1'b1, 4'b1111, 1'b1);
      queue_item(CMD_SAVE, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_DISCARD, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_TICK, 1'b1, 4'b0000, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b0001, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b0000, 1'b0);
      queue_item(CMD_TICK, 1'b0, 4'b0010, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b0110, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b1110, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b0000, 1'b0);
      queue_item(CMD_TICK, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_SAVE, 1'b1, 4'b1111, 1'b0);
      queue_item(CMD_TICK, 1'b1, 4'b1111, 1'b1);
      queue_item(CMD_SAVE, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_DISCARD, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_RESET, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_TICK, 1'b1, 4'b0000, 1'b1);
      queue_item(CMD_START, 1'b0, 4'b0000, 1'b1);
      queue_item(CMD_TICK, 1'b0, 4'b0000, 1'b1);
      drain();

      // Random runs: sender idles less first, then the receiver, then neither.
      run_phase_mix(LOCKOUT_BITS'($urandom_range(1, 12)), 18, 49, 420);
      run_phase_mix('0, 18, 49, 280);
      run_phase_mix({LOCKOUT_BITS{1'b1}}, 49, 18, 90);
      run_phase_mix(LOCKOUT_BITS'($urandom_range(13, 40)), 49, 18, 380);
      run_phase_mix(LOCKOUT_BITS'($urandom_range(0, 6)), 0, 0, 280);

      $display("Drove %0d requests and %0d lockout writes across five idling phases.",
               accepted_count, lockout_writes);
      $display("Checked %0d results, %0d of them records and %0d prompts.",
               checked_count, record_count, prompt_count);
      if (error_count == 0) begin
         $display("four_gate_split_timer_test: done, clean");
      end else begin
         $display("four_gate_split_timer_test: done, errors");
      end
      $finish;
   end

endmodule
